// File: design/sasa_pkg.sv
// Shared types and constants for the shadow atlas slot allocator.
`timescale 1ns / 1ps

package sasa_pkg;

    // Fixed field widths
    localparam int ATLAS_W = 10;
    localparam int PROJ_W  = 11;
    localparam int TILE_W  = 11;
    localparam int FIRST_W = 8;
    localparam int COUNT_W = 9;
    localparam int SLOT_W  = 10;

    // Light type codes
    localparam logic [1:0] LIGHT_DIR   = 2'd0;
    localparam logic [1:0] LIGHT_POINT = 2'd1;
    localparam logic [1:0] LIGHT_SPOT  = 2'd2;

    localparam int NUM_TYPES = 3;

    // Per-type record of shadowed lights
    typedef struct packed {
        logic               present;
        logic [FIRST_W-1:0] first;
        logic [COUNT_W-1:0] count;
    } sasa_rec_t;

    typedef sasa_rec_t [NUM_TYPES-1:0] sasa_rec_arr_t;

    // Frame counters of fixed width
    typedef struct packed {
        logic [PROJ_W-1:0] proj;
        logic [TILE_W-1:0] tile;
    } sasa_ctr_t;

    // One result item
    typedef struct packed {
        logic [7:0]         linear_index;
        logic [SLOT_W-1:0]  projection_slot;
        logic               has_tile;
        logic [SLOT_W-1:0]  tile_slot;
        logic               type_first_valid;
        logic [FIRST_W-1:0] type_first;
        logic [COUNT_W-1:0] type_count;
    } sasa_result_t;

endpackage

// File: design/shadow_atlas_slot_allocator.sv
// Top level of the shadow atlas slot allocator: handshakes, frame state, result register.
`timescale 1ns / 1ps

// One light request is taken per cycle and its result appears in the result register: the
// request lands in an input register, the allocation logic (counter adds and compares) reads
// that register and the result register loads together with the frame counters, so each light
// sees the state left by the one before it. Sustained rate is one light per cycle; a stall on
// the result side holds the result register and then the input register, and in_stall rises
// only when both are full. The atlas size register is written through the cfg port at any
// time (cfg_ready is always high) but must only change while no light is in flight.
module shadow_atlas_slot_allocator
    import sasa_pkg::*;
#(
    parameter int CASCADES   = 4,
    parameter int MAX_LIGHTS = 256
)
(
    input  logic                clk,
    input  logic                rst_n,
    // Light requests
    input  logic                in_valid,
    output logic                in_stall,
    input  logic                frame_start,
    input  logic [1:0]          light_type,
    input  logic                casts_shadow,
    // Allocation results
    output logic                out_valid,
    input  logic                out_stall,
    output logic [7:0]          linear_index,
    output logic [SLOT_W-1:0]   projection_slot,
    output logic                has_tile,
    output logic [SLOT_W-1:0]   tile_slot,
    output logic                type_first_valid,
    output logic [FIRST_W-1:0]  type_first,
    output logic [COUNT_W-1:0]  type_count,
    // Atlas size register
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [ATLAS_W-1:0]  cfg_data
);

    localparam int LC_W = $clog2(MAX_LIGHTS + 1);

    logic               s1_valid_reg;
    logic               s1_frame_start_reg;
    logic [1:0]         s1_type_reg;
    logic               s1_shadow_reg;
    logic               out_valid_reg;
    sasa_result_t       res_reg;
    logic [ATLAS_W-1:0] atlas_reg;
    logic [LC_W-1:0]    lc_reg;
    sasa_ctr_t          ctr_reg;
    sasa_rec_arr_t      recs_reg;

    logic [LC_W-1:0]    lc_next;
    sasa_ctr_t          ctr_next;
    sasa_rec_arr_t      recs_next;
    sasa_result_t       res_next;
    logic               advance;
    logic               in_take;
    logic               s1_fire;

    // Handshake control
    assign advance   = !out_valid_reg || !out_stall;
    assign s1_fire   = s1_valid_reg && advance;
    assign in_stall  = s1_valid_reg && !advance;
    assign in_take   = in_valid && !in_stall;
    assign cfg_ready = 1'b1;

    sasa_calc #(
        .CASCADES   (CASCADES),
        .MAX_LIGHTS (MAX_LIGHTS),
        .LC_W       (LC_W)
    ) u_calc (
        .frame_start  (s1_frame_start_reg),
        .light_type   (s1_type_reg),
        .casts_shadow (s1_shadow_reg),
        .atlas_tiles  (atlas_reg),
        .lc_cur       (lc_reg),
        .ctr_cur      (ctr_reg),
        .recs_cur     (recs_reg),
        .lc_next      (lc_next),
        .ctr_next     (ctr_next),
        .recs_next    (recs_next),
        .result       (res_next)
    );

    // Hold the atlas size
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            atlas_reg <= ATLAS_W'(32);
        end
        else if (cfg_valid && cfg_ready)
        begin
            atlas_reg <= cfg_data;
        end
    end

    // Advance the valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_take)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_fire)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (advance)
            begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    // Capture the request
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_frame_start_reg <= frame_start;
            s1_type_reg        <= light_type;
            s1_shadow_reg      <= casts_shadow;
        end
    end

    // Update the frame state as a light moves to the result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lc_reg   <= '0;
            ctr_reg  <= '0;
            recs_reg <= '0;
        end
        else if (s1_fire)
        begin
            lc_reg   <= lc_next;
            ctr_reg  <= ctr_next;
            recs_reg <= recs_next;
        end
    end

    // Load the result
    always_ff @(posedge clk)
    begin
        if (s1_fire)
        begin
            res_reg <= res_next;
        end
    end

    assign out_valid        = out_valid_reg;
    assign linear_index     = res_reg.linear_index;
    assign projection_slot  = res_reg.projection_slot;
    assign has_tile         = res_reg.has_tile;
    assign tile_slot        = res_reg.tile_slot;
    assign type_first_valid = res_reg.type_first_valid;
    assign type_first       = res_reg.type_first;
    assign type_count       = res_reg.type_count;

    // A frame-start light is always the first of its frame
    a_frame_index_zero: assert property (@(posedge clk) disable iff (!rst_n)
        s1_fire && s1_frame_start_reg |=> linear_index == 8'd0)
        else $error("frame start light did not get index zero");

    // A granted tile is always counted in its type record
    a_tile_recorded: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && has_tile |-> type_first_valid && (type_count != '0))
        else $error("granted tile missing from type record");

    // No tile means tile slot reads zero
    a_no_tile_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !has_tile |-> tile_slot == '0)
        else $error("tile slot nonzero without a tile");

endmodule

// File: design/sasa_calc.sv
// Combinational slot allocation for one light: result and next frame state.
`timescale 1ns / 1ps

module sasa_calc
    import sasa_pkg::*;
#(
    parameter int CASCADES   = 4,
    parameter int MAX_LIGHTS = 256,
    parameter int LC_W       = $clog2(MAX_LIGHTS + 1)
)
(
    input  logic                frame_start,
    input  logic [1:0]          light_type,
    input  logic                casts_shadow,
    input  logic [ATLAS_W-1:0]  atlas_tiles,
    input  logic [LC_W-1:0]     lc_cur,
    input  sasa_ctr_t           ctr_cur,
    input  sasa_rec_arr_t       recs_cur,
    output logic [LC_W-1:0]     lc_next,
    output sasa_ctr_t           ctr_next,
    output sasa_rec_arr_t       recs_next,
    output sasa_result_t        result
);

    localparam int IDX_W  = $clog2(MAX_LIGHTS);
    localparam int CMP_W  = (IDX_W > FIRST_W) ? IDX_W : FIRST_W;
    localparam int PSUM_W = PROJ_W + 1;

    logic [LC_W-1:0]   lc;
    sasa_ctr_t         ctr;
    sasa_rec_arr_t     recs;
    logic [IDX_W-1:0]  idx;
    logic [CMP_W-1:0]  idx_ext;
    logic              is_dir;
    logic              is_spot;
    logic              is_known;
    logic [PSUM_W-1:0] proj_sum;
    logic [TILE_W-1:0] atlas_ext;
    logic [TILE_W-1:0] room;
    logic              got;
    sasa_rec_t         rec;
    sasa_rec_t         rec_upd;

    always_comb
    begin
        // Drop the frame state on frame start
        lc   = frame_start ? '0 : lc_cur;
        ctr  = frame_start ? '0 : ctr_cur;
        recs = frame_start ? '0 : recs_cur;

        // Linear index, saturating at the last light
        if (lc < LC_W'(MAX_LIGHTS))
        begin
            idx     = IDX_W'(lc);
            lc_next = lc + LC_W'(1);
        end
        else
        begin
            idx     = IDX_W'(MAX_LIGHTS - 1);
            lc_next = lc;
        end
        idx_ext = CMP_W'(idx);

        is_dir   = (light_type == LIGHT_DIR);
        is_spot  = (light_type == LIGHT_SPOT);
        is_known = is_dir || is_spot || (light_type == LIGHT_POINT);

        // Projection slots: directional takes a cascade set, spot takes one
        proj_sum = {1'b0, ctr.proj} + (is_dir ? PSUM_W'(CASCADES) : PSUM_W'(1));
        ctr_next.proj = ctr.proj;
        if (is_dir || is_spot)
        begin
            ctr_next.proj = proj_sum[PSUM_W-1] ? '1 : proj_sum[PROJ_W-1:0];
        end

        // Atlas tiles, only while room remains
        atlas_ext = TILE_W'(atlas_tiles);
        room      = atlas_ext - ctr.tile;
        got       = casts_shadow && is_known && (ctr.tile < atlas_ext)
                    && (!is_dir || (room >= TILE_W'(CASCADES)));
        ctr_next.tile = ctr.tile;
        if (got)
        begin
            ctr_next.tile = ctr.tile + (is_dir ? TILE_W'(CASCADES) : TILE_W'(1));
        end

        // Select the record of this light's type
        unique case (light_type)
            LIGHT_DIR:   rec = recs[0];
            LIGHT_POINT: rec = recs[1];
            LIGHT_SPOT:  rec = recs[2];
            default:     rec = '0;
        endcase

        // Update the record when a tile was granted
        rec_upd = rec;
        if (got)
        begin
            if (!rec.present || (idx_ext < CMP_W'(rec.first)))
            begin
                rec_upd.first   = idx_ext[FIRST_W-1:0];
                rec_upd.present = 1'b1;
            end
            if (rec.count != '1)
            begin
                rec_upd.count = rec.count + COUNT_W'(1);
            end
        end

        recs_next = recs;
        unique case (light_type)
            LIGHT_DIR:   recs_next[0] = rec_upd;
            LIGHT_POINT: recs_next[1] = rec_upd;
            LIGHT_SPOT:  recs_next[2] = rec_upd;
            default:     recs_next    = recs;
        endcase

        // Assemble the result
        result.linear_index     = idx_ext[7:0];
        result.projection_slot  = '0;
        if (is_dir || is_spot)
        begin
            result.projection_slot = ctr.proj[PROJ_W-1] ? '1 : ctr.proj[SLOT_W-1:0];
        end
        result.has_tile         = got;
        result.tile_slot        = got ? ctr.tile[SLOT_W-1:0] : '0;
        result.type_first_valid = rec_upd.present;
        result.type_first       = rec_upd.present ? rec_upd.first : '0;
        result.type_count       = rec_upd.count;
    end

endmodule

// File: bench/shadow_atlas_slot_allocator_test.sv
// Self-checking testbench for the shadow atlas slot allocator: directed script, random frames, then two long frames.
`timescale 1ns / 1ps

module shadow_atlas_slot_allocator_test;
    import sasa_pkg::*;

    localparam int CASCADES      = 4;
    localparam int MAX_LIGHTS    = 256;
    localparam int PROJ_CAP      = 2047;
    localparam int SLOT_CAP      = 1023;
    localparam int COUNT_CAP     = 511;
    localparam int DRAIN_GAP     = 4;
    localparam int QUIET_LIMIT   = 2000;
    localparam int HOLD_CYCLES   = 80;
    localparam int HOLD_AFTER    = 150;
    localparam int MAX_REPORTS   = 10;
    localparam int IDLE_PCT      = 37;
    localparam logic [1:0] LIGHT_UNKNOWN = 2'd3;

    typedef enum logic { ROW_LIGHT, ROW_ATLAS } row_kind_e;

    typedef struct {
        row_kind_e    kind;
        logic         fs;
        logic [1:0]   ltype;
        logic         shadow;
        logic [9:0]   atlas;
        bit           typed;
        sasa_result_t want;
    } script_row_t;

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_stall;
    logic                frame_start;
    logic [1:0]          light_type;
    logic                casts_shadow;
    logic                out_valid;
    logic                out_stall;
    logic [7:0]          linear_index;
    logic [SLOT_W-1:0]   projection_slot;
    logic                has_tile;
    logic [SLOT_W-1:0]   tile_slot;
    logic                type_first_valid;
    logic [FIRST_W-1:0]  type_first;
    logic [COUNT_W-1:0]  type_count;
    logic                cfg_valid;
    logic                cfg_ready;
    logic [ATLAS_W-1:0]  cfg_data;

    // Allocator state as this bench tracks it
    logic [9:0]          atlas_limit;
    logic [8:0]          light_ctr;
    logic [10:0]         proj_ctr;
    logic [10:0]         tile_ctr;
    logic [2:0]          rec_present;
    logic [7:0]          rec_first [3];
    logic [8:0]          rec_count [3];

    sasa_result_t        pending_allocs [$];
    script_row_t         script [$];
    int                  mismatch_count;
    int                  lights_sent;
    int                  quiet_cycles;
    int                  hold_left;
    bit                  hold_done;
    bit                  no_gaps;

    shadow_atlas_slot_allocator #(
        .CASCADES   (CASCADES),
        .MAX_LIGHTS (MAX_LIGHTS)
    ) dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .frame_start      (frame_start),
        .light_type       (light_type),
        .casts_shadow     (casts_shadow),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .linear_index     (linear_index),
        .projection_slot  (projection_slot),
        .has_tile         (has_tile),
        .tile_slot        (tile_slot),
        .type_first_valid (type_first_valid),
        .type_first       (type_first),
        .type_count       (type_count),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_data         (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    // Advance the tracked state by one light and return its allocation
    function automatic sasa_result_t allocate_light(logic fs, logic [1:0] ltype, logic shadow);
        int           idx;
        int           proj;
        int           tile;
        int           k;
        logic         got;
        sasa_result_t r;
        proj = 0;
        tile = 0;
        got  = 1'b0;
        if (fs)
        begin
            light_ctr   = '0;
            proj_ctr    = '0;
            tile_ctr    = '0;
            rec_present = '0;
            for (k = 0; k < 3; k++)
            begin
                rec_first[k] = '0;
                rec_count[k] = '0;
            end
        end
        idx = (int'(light_ctr) < MAX_LIGHTS) ? int'(light_ctr) : MAX_LIGHTS - 1;
        if (int'(light_ctr) < MAX_LIGHTS)
            light_ctr = light_ctr + 9'd1;
        // Directional takes one projection slot per cascade, spot takes one
        if (ltype == LIGHT_DIR || ltype == LIGHT_SPOT)
        begin
            proj = int'(proj_ctr);
            k = proj + ((ltype == LIGHT_DIR) ? CASCADES : 1);
            proj_ctr = 11'((k > PROJ_CAP) ? PROJ_CAP : k);
        end
        // Atlas tiles while room remains; directional needs a full cascade set
        if (shadow && ltype != LIGHT_UNKNOWN && tile_ctr < 11'(atlas_limit))
        begin
            if (ltype == LIGHT_DIR)
            begin
                if (int'(atlas_limit) - int'(tile_ctr) >= CASCADES)
                begin
                    tile     = int'(tile_ctr);
                    tile_ctr = tile_ctr + 11'(CASCADES);
                    got      = 1'b1;
                end
            end
            else
            begin
                tile     = int'(tile_ctr);
                tile_ctr = tile_ctr + 11'd1;
                got      = 1'b1;
            end
        end
        if (got)
        begin
            if (!rec_present[ltype] || 8'(idx) < rec_first[ltype])
            begin
                rec_first[ltype]   = 8'(idx);
                rec_present[ltype] = 1'b1;
            end
            if (int'(rec_count[ltype]) < COUNT_CAP)
                rec_count[ltype] = rec_count[ltype] + 9'd1;
        end
        r = '0;
        r.linear_index    = 8'(idx);
        r.projection_slot = SLOT_W'((proj > SLOT_CAP) ? SLOT_CAP : proj);
        r.has_tile        = got;
        r.tile_slot       = got ? SLOT_W'(tile) : '0;
        if (ltype != LIGHT_UNKNOWN)
        begin
            r.type_first_valid = rec_present[ltype];
            r.type_first       = rec_present[ltype] ? rec_first[ltype] : '0;
            r.type_count       = rec_count[ltype];
        end
        return r;
    endfunction

    function automatic void add_step(row_kind_e kind, logic fs, logic [1:0] ltype, logic shadow,
                                     logic [9:0] atlas, bit typed, sasa_result_t want);
        script_row_t row;
        row.kind   = kind;
        row.fs     = fs;
        row.ltype  = ltype;
        row.shadow = shadow;
        row.atlas  = atlas;
        row.typed  = typed;
        row.want   = want;
        script.push_back(row);
    endfunction

    // Offer one light request, hold it until accepted, then queue its expected result
    task automatic offer_light(logic fs, logic [1:0] ltype, logic shadow, bit typed,
                               sasa_result_t want);
        sasa_result_t predicted;
        while (!no_gaps && $urandom_range(99) < IDLE_PCT)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid     <= 1'b1;
        frame_start  <= fs;
        light_type   <= ltype;
        casts_shadow <= shadow;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predicted = allocate_light(fs, ltype, shadow);
        pending_allocs.push_back(typed ? want : predicted);
        lights_sent++;
    endtask

    // Drain the pipeline, then write the atlas size
    task automatic set_atlas(logic [9:0] tiles);
        in_valid <= 1'b0;
        while (pending_allocs.size() != 0)
            @(posedge clk);
        repeat (DRAIN_GAP) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= tiles;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid   <= 1'b0;
        atlas_limit = tiles;
    endtask

    // Well-formed frame: shadowed lights first, each group sorted by type
    task automatic emit_frame(int size, bit with_start);
        int tally [2][3];
        int n;
        int sh;
        int t;
        int i;
        bit first;
        for (sh = 0; sh < 2; sh++)
            for (t = 0; t < 3; t++)
                tally[sh][t] = 0;
        for (n = 0; n < size; n++)
            tally[$urandom_range(1)][$urandom_range(2)]++;
        first = with_start;
        for (sh = 1; sh >= 0; sh--)
            for (t = 0; t < 3; t++)
                for (i = 0; i < tally[sh][t]; i++)
                begin
                    offer_light(first, 2'(t), 1'(sh), 1'b0, '0);
                    first = 1'b0;
                end
    endtask

    // Unordered lights, unknown type included, stray frame starts
    task automatic emit_noise(int size);
        int i;
        for (i = 0; i < size; i++)
            offer_light($urandom_range(19) == 0, 2'($urandom_range(3)),
                        1'($urandom_range(1)), 1'b0, '0);
    endtask

    // Result side: random stalls, plus one long hold to back up the pipeline
    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end
        else if (!hold_done && lights_sent >= HOLD_AFTER)
        begin
            out_stall <= 1'b1;
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
        else
            out_stall <= !no_gaps && ($urandom_range(99) < IDLE_PCT);
    end

    // Compare each accepted result against the oldest expectation
    always @(posedge clk)
    begin
        sasa_result_t exp_r;
        sasa_result_t got_r;
        if (rst_n && out_valid && !out_stall)
        begin
            got_r = '{linear_index, projection_slot, has_tile, tile_slot,
                      type_first_valid, type_first, type_count};
            if (pending_allocs.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("unexpected result: idx=%0d proj=%0d tile=%0b/%0d rec=%0b/%0d/%0d",
                             got_r.linear_index, got_r.projection_slot, got_r.has_tile,
                             got_r.tile_slot, got_r.type_first_valid, got_r.type_first,
                             got_r.type_count);
            end
            else
            begin
                exp_r = pending_allocs.pop_front();
                if (got_r.linear_index !== exp_r.linear_index
                    || got_r.projection_slot !== exp_r.projection_slot
                    || got_r.has_tile !== exp_r.has_tile
                    || got_r.tile_slot !== exp_r.tile_slot
                    || got_r.type_first_valid !== exp_r.type_first_valid
                    || got_r.type_first !== exp_r.type_first
                    || got_r.type_count !== exp_r.type_count)
                begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                    begin
                        $write("mismatch: exp idx=%0d proj=%0d tile=%0b/%0d rec=%0b/%0d/%0d,",
                               exp_r.linear_index, exp_r.projection_slot, exp_r.has_tile,
                               exp_r.tile_slot, exp_r.type_first_valid, exp_r.type_first,
                               exp_r.type_count);
                        $display(" got idx=%0d proj=%0d tile=%0b/%0d rec=%0b/%0d/%0d",
                                 got_r.linear_index, got_r.projection_slot, got_r.has_tile,
                                 got_r.tile_slot, got_r.type_first_valid, got_r.type_first,
                                 got_r.type_count);
                    end
                end
            end
        end
    end

    // End the run when nothing moves on any channel for too long
    always @(posedge clk)
    begin
        if (!rst_n
            || (in_valid && !in_stall)
            || (out_valid && !out_stall)
            || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        logic [9:0]  atlas_plan [8];
        script_row_t row;
        int          p;
        int          i;
        int          phase_base;
        int          size;

        rst_n        = 1'b0;
        in_valid     = 1'b0;
        frame_start  = 1'b0;
        light_type   = LIGHT_DIR;
        casts_shadow = 1'b0;
        out_stall    = 1'b0;
        cfg_valid    = 1'b0;
        cfg_data     = '0;
        mismatch_count = 0;
        lights_sent  = 0;
        quiet_cycles = 0;
        hold_left    = 0;
        hold_done    = 1'b0;
        no_gaps      = 1'b0;
        atlas_limit  = 10'd32;
        light_ctr    = '0;
        proj_ctr     = '0;
        tile_ctr     = '0;
        rec_present  = '0;
        for (i = 0; i < 3; i++)
        begin
            rec_first[i] = '0;
            rec_count[i] = '0;
        end

        // Directed script; the atlas starts at its reset size
        add_step(ROW_LIGHT, 1, LIGHT_DIR, 1, 0, 1,
                 sasa_result_t'{8'd0, 10'd0, 1'b1, 10'd0, 1'b1, 8'd0, 9'd1});
        add_step(ROW_LIGHT, 0, LIGHT_DIR, 1, 0, 0, '0);
        add_step(ROW_LIGHT, 0, LIGHT_POINT, 1, 0, 0, '0);
        add_step(ROW_LIGHT, 0, LIGHT_SPOT, 1, 0, 0, '0);
        add_step(ROW_LIGHT, 0, LIGHT_SPOT, 0, 0, 0, '0);
        add_step(ROW_LIGHT, 0, LIGHT_UNKNOWN, 1, 0, 1,
                 sasa_result_t'{8'd5, 10'd0, 1'b0, 10'd0, 1'b0, 8'd0, 9'd0});
        add_step(ROW_LIGHT, 0, LIGHT_POINT, 0, 0, 0, '0);
        // Shrink the atlas below the tiles already handed out
        add_step(ROW_ATLAS, 0, LIGHT_DIR, 0, 10'd5, 0, '0);
        add_step(ROW_LIGHT, 0, LIGHT_POINT, 1, 0, 0, '0);
        add_step(ROW_LIGHT, 1, LIGHT_POINT, 1, 0, 1,
                 sasa_result_t'{8'd0, 10'd0, 1'b1, 10'd0, 1'b1, 8'd0, 9'd1});
        add_step(ROW_LIGHT, 0, LIGHT_DIR, 1, 0, 0, '0);
        add_step(ROW_LIGHT, 0, LIGHT_SPOT, 1, 0, 0, '0);
        add_step(ROW_LIGHT, 1, LIGHT_DIR, 1, 0, 1,
                 sasa_result_t'{8'd0, 10'd0, 1'b1, 10'd0, 1'b1, 8'd0, 9'd1});
        // Too few tiles left for a cascade set, one left for a point light
        add_step(ROW_LIGHT, 0, LIGHT_DIR, 1, 0, 0, '0);
        add_step(ROW_LIGHT, 0, LIGHT_POINT, 1, 0, 0, '0);
        add_step(ROW_ATLAS, 0, LIGHT_DIR, 0, 10'd0, 0, '0);
        add_step(ROW_LIGHT, 1, LIGHT_SPOT, 1, 0, 1,
                 sasa_result_t'{8'd0, 10'd0, 1'b0, 10'd0, 1'b0, 8'd0, 9'd0});
        add_step(ROW_LIGHT, 0, LIGHT_UNKNOWN, 0, 0, 0, '0);
        add_step(ROW_ATLAS, 0, LIGHT_DIR, 0, 10'd1023, 0, '0);
        add_step(ROW_LIGHT, 1, LIGHT_UNKNOWN, 0, 0, 1,
                 sasa_result_t'{8'd0, 10'd0, 1'b0, 10'd0, 1'b0, 8'd0, 9'd0});
        add_step(ROW_LIGHT, 0, LIGHT_DIR, 1, 0, 0, '0);
        add_step(ROW_LIGHT, 0, LIGHT_SPOT, 0, 0, 0, '0);
        add_step(ROW_LIGHT, 0, LIGHT_POINT, 1, 0, 0, '0);

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (script[i])
        begin
            row = script[i];
            if (row.kind == ROW_ATLAS)
                set_atlas(row.atlas);
            else
                offer_light(row.fs, row.ltype, row.shadow, row.typed, row.want);
        end

        // Random frames over a range of atlas sizes; frames carry across writes
        atlas_plan = '{10'd5, 10'd4, 10'd3, 10'd1, 10'd0, 10'd1023, 10'd32, 10'd0};
        atlas_plan[7] = 10'($urandom_range(1023));
        for (p = 0; p < 8; p++)
        begin
            set_atlas(atlas_plan[p]);
            phase_base = lights_sent;
            while (lights_sent - phase_base < 90)
            begin
                size = ($urandom_range(24) == 0) ? $urandom_range(60, 280)
                                                 : $urandom_range(1, 24);
                if ($urandom_range(99) < 85)
                    emit_frame(size, $urandom_range(9) != 0);
                else
                    emit_noise(size);
            end
        end

        // One long point-light frame: index and type count saturate
        set_atlas(10'd1023);
        for (i = 0; i < 560; i++)
            offer_light(i == 0, LIGHT_POINT, i < 530, 1'b0, '0);

        // Directional flood with no gaps: projection saturates, atlas runs out
        set_atlas(10'd1023);
        no_gaps = 1'b1;
        for (i = 0; i < 290; i++)
            offer_light(i == 0, LIGHT_DIR, 1'b1, 1'b0, '0);
        for (i = 0; i < 10; i++)
            offer_light(1'b0, LIGHT_SPOT, 1'b1, 1'b0, '0);
        for (i = 0; i < 10; i++)
            offer_light(1'b0, LIGHT_DIR, 1'b0, 1'b0, '0);
        no_gaps = 1'b0;

        in_valid <= 1'b0;
        while (pending_allocs.size() != 0)
            @(posedge clk);
        repeat (DRAIN_GAP) @(posedge clk);

        if (mismatch_count == 0 && pending_allocs.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// File: shadow_atlas_slot_allocator.f
design/sasa_pkg.sv
design/sasa_calc.sv
design/shadow_atlas_slot_allocator.sv
bench/shadow_atlas_slot_allocator_test.sv
